// File: rtl/ffba_pkg.sv
// shared types and constants for the first-fit byte allocator
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
    localparam int HEAP_BYTES_DEF  = 256;
    localparam int MAX_EXTENTS_DEF = 32;
    localparam int ALIGNMENT_DEF   = 1;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [2:0] ST_DONE       = 3'd0;
    localparam logic [2:0] ST_ZERO_LEN   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_NO_ROOM    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN    = 3'd4;
    localparam logic [2:0] ST_NULL       = 3'd5;

    typedef struct packed {
        logic       operation;
        logic [8:0] request_length;
        logic [7:0] free_offset;
        logic       free_is_null;
    } t_req;

    typedef struct packed {
        logic [7:0] block_offset;
        logic [2:0] status;
        logic [5:0] blocks_in_use;
    } t_rsp;
endpackage
`default_nettype wire

// File: rtl/ffba_cell.sv
// one table cell: holds an extent, compares it against the probe and shifts for compaction
`timescale 1ns / 1ps
`default_nettype none
module ffba_cell #(
    parameter int AW = 8,
    parameter int LW = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid_in,
    input  wire logic          i_load,
    input  wire logic [AW-1:0] i_load_start,
    input  wire logic [LW-1:0] i_load_len,
    input  wire logic          i_shift,
    input  wire logic          i_nb_valid,
    input  wire logic [AW-1:0] i_nb_start,
    input  wire logic [LW-1:0] i_nb_len,
    input  wire logic [AW:0]   i_pos,
    input  wire logic [AW:0]   i_plen,
    output logic               o_valid,
    output logic [AW-1:0]      o_start,
    output logic [LW-1:0]      o_len,
    output logic               o_hit,
    output logic [AW:0]        o_end
);
    logic          r_valid;
    logic [AW-1:0] r_start;
    logic [LW-1:0] r_len;
    logic [AW+1:0] w_pend;
    logic [AW+1:0] w_send;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_start <= i_load_start;
            r_len   <= i_load_len;
        end else if (i_shift) begin
            r_valid <= i_nb_valid;
            r_start <= i_nb_start;
            r_len   <= i_nb_len;
        end
    end

    assign w_pend = {1'b0, i_pos} + {1'b0, i_plen};
    assign w_send = {2'b00, r_start} + (AW+2)'(r_len);
    assign o_valid = r_valid;
    assign o_start = r_start;
    assign o_len   = r_len;
    assign o_hit   = r_valid && i_valid_in && ({2'b00, r_start} < w_pend)
                     && ({1'b0, i_pos} < w_send);
    // end of extent, used to jump the candidate past it
    assign o_end   = w_send[AW:0];
endmodule
`default_nettype wire

// File: rtl/first_fit_byte_allocator.sv
// top level of the first-fit byte allocator: control sequencer and chain of extent cells
// An allocate probes one candidate offset per cycle against all cells in parallel and, on an
// overlap, jumps past the hit extent; a free matches the offset and compacts the chain in
// one shift.
// Results wait in an output register; a new request is taken once that register is empty.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_byte_allocator #(
    parameter int HEAP_BYTES  = ffba_pkg::HEAP_BYTES_DEF,
    parameter int MAX_EXTENTS = ffba_pkg::MAX_EXTENTS_DEF,
    parameter int ALIGNMENT   = ffba_pkg::ALIGNMENT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    output logic                 o_req_ready,
    input  wire ffba_pkg::t_req  i_req,
    output logic                 o_rsp_valid,
    input  wire logic            i_rsp_ready,
    output ffba_pkg::t_rsp       o_rsp
);
    localparam int AW = 8;
    localparam int LW = 9;
    localparam int CW = $clog2(MAX_EXTENTS + 1);
    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    // reciprocal of the alignment for rounding the candidate up
    localparam int RS = 14;
    localparam int RM = ((1 << RS) + ALIGNMENT - 1) / ALIGNMENT;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FREE = 2'd2;

    logic [1:0]       r_state;
    ffba_pkg::t_req   r_req;
    logic [AW:0]      r_pos;
    logic [CW-1:0]    r_count;
    logic             r_out_v;
    ffba_pkg::t_rsp   r_out;

    logic [MAX_EXTENTS-1:0] w_valid, w_hit, w_match, w_load, w_shift;
    logic [MAX_EXTENTS-1:0] w_hit_low;
    logic [AW-1:0]          w_start [MAX_EXTENTS];
    logic [LW-1:0]          w_len   [MAX_EXTENTS];
    logic [AW:0]            w_end   [MAX_EXTENTS];
    logic [AW:0]            w_jump, w_jump_al;
    logic [AW:0]            w_jump_up;
    logic [AW+RS+1:0]       w_prod;
    logic [AW:0]            w_quot;
    logic [IW-1:0]          w_first;
    logic                   w_any_match;
    logic [AW+1:0]          w_lim;
    logic                   w_scan;

    assign w_scan = (r_state == S_SCAN);

    genvar g;
    generate
        for (g = 0; g < MAX_EXTENTS; g++) begin : g_cell
            logic          w_nv;
            logic [AW-1:0] w_ns;
            logic [LW-1:0] w_nl;
            if (g == MAX_EXTENTS - 1) begin : g_last
                assign w_nv = 1'b0;
                assign w_ns = '0;
                assign w_nl = '0;
            end else begin : g_mid
                assign w_nv = w_valid[g+1];
                assign w_ns = w_start[g+1];
                assign w_nl = w_len[g+1];
            end
            ffba_cell #(.AW(AW), .LW(LW)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid_in(w_scan),
                .i_load(w_load[g]), .i_load_start(r_pos[AW-1:0]),
                .i_load_len(r_req.request_length), .i_shift(w_shift[g]),
                .i_nb_valid(w_nv), .i_nb_start(w_ns), .i_nb_len(w_nl),
                .i_pos(r_pos), .i_plen(r_req.request_length),
                .o_valid(w_valid[g]), .o_start(w_start[g]), .o_len(w_len[g]),
                .o_hit(w_hit[g]), .o_end(w_end[g])
            );
            assign w_match[g] = w_valid[g] && (w_start[g] == r_req.free_offset);
        end
    endgenerate

    // every candidate below the end of an overlapping extent overlaps it too
    assign w_hit_low = w_hit & (~w_hit + 1'b1);

    // end of the overlapping extent in the lowest-index cell and lowest matching index
    always_comb begin
        w_jump      = '0;
        w_first     = '0;
        w_any_match = 1'b0;
        for (int k = MAX_EXTENTS - 1; k >= 0; k--) begin
            if (w_match[k]) begin
                w_first     = IW'(k);
                w_any_match = 1'b1;
            end
        end
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            w_jump = w_jump | (w_end[k] & {(AW+1){w_hit_low[k]}});
        end
    end
    assign w_jump_up = w_jump + (AW+1)'(ALIGNMENT - 1);
    assign w_prod    = (AW+RS+2)'(w_jump_up) * (AW+RS+2)'(RM);
    assign w_quot    = w_prod[AW+RS:RS];
    assign w_jump_al = w_quot * (AW+1)'(ALIGNMENT);

    always_comb begin
        for (int k = 0; k < MAX_EXTENTS; k++) begin
            w_load[k]  = w_scan && (w_hit == '0)
                         && (w_lim <= (AW+2)'(HEAP_BYTES)) && (r_count == CW'(k));
            w_shift[k] = (r_state == S_FREE) && w_any_match && (IW'(k) >= w_first);
        end
    end
    assign w_lim = {1'b0, r_pos} + {1'b0, r_req.request_length};
    assign o_req_ready = (r_state == S_IDLE) && !r_out_v;
    assign o_rsp_valid = r_out_v;
    assign o_rsp = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (r_out_v && i_rsp_ready) r_out_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid && o_req_ready) begin
                        r_req <= i_req;
                        r_pos <= '0;
                        r_out.block_offset <= '0;
                        r_out.blocks_in_use <= 6'(r_count);
                        if (i_req.operation == ffba_pkg::OP_ALLOC) begin
                            if (i_req.request_length == '0) begin
                                r_out.status <= ffba_pkg::ST_ZERO_LEN;
                                r_out_v <= 1'b1;
                            end else if (r_count >= CW'(MAX_EXTENTS)) begin
                                r_out.status <= ffba_pkg::ST_TABLE_FULL;
                                r_out_v <= 1'b1;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if (i_req.free_is_null) begin
                            r_out.status <= ffba_pkg::ST_NULL;
                            r_out_v <= 1'b1;
                        end else begin
                            r_state <= S_FREE;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_lim > (AW+2)'(HEAP_BYTES)) begin
                        r_out.status <= ffba_pkg::ST_NO_ROOM;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (w_hit == '0) begin
                        r_out.status <= ffba_pkg::ST_DONE;
                        r_out.block_offset <= r_pos[AW-1:0];
                        r_out.blocks_in_use <= 6'(r_count + 1'b1);
                        r_count <= r_count + 1'b1;
                        r_out_v <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_pos <= w_jump_al;
                    end
                end
                S_FREE: begin
                    if (w_any_match) begin
                        r_out.status <= ffba_pkg::ST_DONE;
                        r_out.blocks_in_use <= 6'(r_count - 1'b1);
                        r_count <= r_count - 1'b1;
                    end else begin
                        r_out.status <= ffba_pkg::ST_UNKNOWN;
                    end
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/ffba_checker.sv
// port-level checker for the first-fit byte allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ffba_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_req_valid,
    input wire logic           o_req_ready,
    input wire ffba_pkg::t_req i_req,
    input wire logic           o_rsp_valid,
    input wire logic           i_rsp_ready,
    input wire ffba_pkg::t_rsp o_rsp
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped while stalled");
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !o_req_ready)
        else $error("ready while response pending");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> o_rsp.status <= ffba_pkg::ST_NULL)
        else $error("bad status code");
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != ffba_pkg::ST_DONE |-> o_rsp.block_offset == '0)
        else $error("offset set on failed request");
    a_null_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready && i_req.operation == ffba_pkg::OP_FREE
        && i_req.free_is_null |=> o_rsp_valid && o_rsp.status == ffba_pkg::ST_NULL)
        else $error("null free not answered at once");
endmodule

bind first_fit_byte_allocator ffba_checker u_ffba_checker (.*);
`default_nettype wire

// File: sim/testbench.sv
// self-checking testbench for the first-fit byte allocator
`timescale 1ns / 1ps
module testbench;
    localparam int HEAP  = 256;
    localparam int SLOTS = 32;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_req_valid;
    logic           o_req_ready;
    ffba_pkg::t_req i_req;
    logic           o_rsp_valid;
    logic           i_rsp_ready;
    ffba_pkg::t_rsp o_rsp;

    first_fit_byte_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready), .o_rsp(o_rsp)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // predictor state: extent table in allocation order
    logic [7:0]     ext_start [SLOTS];
    logic [8:0]     ext_len [SLOTS];
    int             ext_count;
    ffba_pkg::t_rsp pending_rsp [$];
    int             errors;
    int             send_idle_pct;
    int             stall_pct;
    int             hold_cycles;

    function automatic bit overlaps(int pos, int len);
        for (int i = 0; i < ext_count; i++) begin
            if (ext_start[i] < pos + len && pos < ext_start[i] + ext_len[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic ffba_pkg::t_rsp allocate_or_free(ffba_pkg::t_req r);
        ffba_pkg::t_rsp p;
        int             idx;
        p.block_offset = '0;
        if (r.operation == ffba_pkg::OP_ALLOC) begin
            if (r.request_length == 0) begin
                p.status = ffba_pkg::ST_ZERO_LEN;
            end else if (ext_count >= SLOTS) begin
                p.status = ffba_pkg::ST_TABLE_FULL;
            end else begin
                p.status = ffba_pkg::ST_NO_ROOM;
                for (int c = 0; c + r.request_length <= HEAP; c++) begin
                    if (!overlaps(c, r.request_length)) begin
                        ext_start[ext_count] = c[7:0];
                        ext_len[ext_count] = r.request_length;
                        ext_count++;
                        p.block_offset = c[7:0];
                        p.status = ffba_pkg::ST_DONE;
                        break;
                    end
                end
            end
        end else if (r.free_is_null) begin
            p.status = ffba_pkg::ST_NULL;
        end else begin
            p.status = ffba_pkg::ST_UNKNOWN;
            idx = -1;
            for (int i = 0; i < ext_count; i++) begin
                if (ext_start[i] == r.free_offset) begin
                    idx = i;
                    break;
                end
            end
            if (idx >= 0) begin
                for (int i = idx; i + 1 < ext_count; i++) begin
                    ext_start[i] = ext_start[i + 1];
                    ext_len[i] = ext_len[i + 1];
                end
                ext_count--;
                p.status = ffba_pkg::ST_DONE;
            end
        end
        p.blocks_in_use = ext_count[5:0];
        return p;
    endfunction

    task automatic send_request(ffba_pkg::t_req r);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            @(posedge i_clk);
            i_req_valid <= 1'b0;
        end
        @(posedge i_clk);
        i_req_valid <= 1'b1;
        i_req <= r;
        pending_rsp.push_back(allocate_or_free(r));
        do @(posedge i_clk); while (!o_req_ready);
        i_req_valid <= 1'b0;
    endtask

    // send_request leaves valid low after acceptance; a following send re-raises it
    // at a later clock edge, so there is never a double assignment in the same step
    task automatic send_alloc(int len);
        ffba_pkg::t_req r;
        r = '0;
        r.operation = ffba_pkg::OP_ALLOC;
        r.request_length = len[8:0];
        r.free_offset = 8'($urandom);
        r.free_is_null = 1'($urandom);
        send_request(r);
    endtask

    task automatic send_free(int offs, bit is_null);
        ffba_pkg::t_req r;
        r.operation = ffba_pkg::OP_FREE;
        r.request_length = 9'($urandom);
        r.free_offset = offs[7:0];
        r.free_is_null = is_null;
        send_request(r);
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        ffba_pkg::t_rsp e;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response with nothing expected");
                errors++;
            end else begin
                e = pending_rsp.pop_front();
                if (o_rsp.block_offset !== e.block_offset) begin
                    $error("block_offset: expected %0d actual %0d",
                           e.block_offset, o_rsp.block_offset);
                    errors++;
                end
                if (o_rsp.status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_rsp.status);
                    errors++;
                end
                if (o_rsp.blocks_in_use !== e.blocks_in_use) begin
                    $error("blocks_in_use: expected %0d actual %0d",
                           e.blocks_in_use, o_rsp.blocks_in_use);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_alloc(0);
        send_alloc(256);
        send_free(0, 1'b1);
        send_free(255, 1'b1);
        send_free(0, 1'b0);
        send_alloc(257);
        send_alloc(511);
        send_free(0, 1'b0);
        for (int i = 0; i < 12; i++) send_alloc(1 + (i % 3) * 8);
        send_free(1, 1'b0);
        send_free(9, 1'b0);
        send_alloc(5);
        send_alloc(255);
        send_free(255, 1'b0);
        // drain so the table starts empty for the next test
        while (ext_count > 0) send_free(ext_start[0], 1'b0);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < SLOTS + 2; i++) send_alloc(1 + (i & 1) * 6);
        send_alloc(0);
        while (ext_count > 0) send_free(ext_start[$urandom_range(ext_count - 1)], 1'b0);
    endtask

    task automatic test_random(int n);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                case ($urandom_range(3))
                    0: send_alloc($urandom_range(1, 8));
                    1: send_alloc($urandom_range(1, 40));
                    2: send_alloc($urandom_range(0, 511));
                    default: send_alloc($urandom_range(100, 256));
                endcase
            end else if (pick < 85 && ext_count > 0) begin
                send_free(ext_start[$urandom_range(ext_count - 1)], 1'b0);
            end else if (pick < 93) begin
                send_free($urandom_range(255), 1'b0);
            end else begin
                send_free($urandom_range(255), 1'b1);
            end
        end
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        stall_pct = 0;
        send_idle_pct = 0;
        test_random(30);
    endtask

    task automatic wait_drain();
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        errors = 0;
        ext_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_table_full();
        test_random(300);
        send_idle_pct = 57;
        test_random(300);
        send_idle_pct = 0;
        stall_pct = 57;
        test_random(300);
        send_idle_pct = 36;
        stall_pct = 36;
        test_random(300);
        test_backpressure();
        stall_pct = 0;
        test_random(200);
        wait_drain();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: files.f
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_byte_allocator.sv
rtl/ffba_checker.sv
sim/testbench.sv
